// ===== rtl/amc_pkg.sv =====
package amc_pkg;

	localparam int unsigned ValW   = 16;
	localparam int unsigned LeverW = 11;
	localparam int unsigned CurW   = 15;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [LeverW-1:0] LeverFull = 11'd1024;
	localparam logic signed [ValW-1:0] HalfQ88 = 16'sd128;

	typedef enum logic [2:0] {
		MODE_INIT  = 3'd0,
		MODE_WAIT  = 3'd1,
		MODE_ROLL  = 3'd2,
		MODE_HOLD  = 3'd3,
		MODE_DECEL = 3'd4,
		MODE_BRAKE = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE        = 2'd0,
		CMD_SET_CURRENT = 2'd1,
		CMD_SET_BRAKE   = 2'd2
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ROLL_SPEED_THR = 3'd0,
		REG_PUSH_THR       = 3'd1,
		REG_DECEL_THR      = 3'd2,
		REG_BRAKE_THR      = 3'd3,
		REG_LEVER_THR      = 3'd4,
		REG_MIN_BRAKE_CUR  = 3'd5,
		REG_MAX_BRAKE_CUR  = 3'd6
	} cfg_reg_t;

	localparam logic signed [ValW-1:0] RstRollSpeedThr = 16'sd256;
	localparam logic signed [ValW-1:0] RstPushThr      = 16'sd256;
	localparam logic signed [ValW-1:0] RstDecelThr     = -16'sd1024;
	localparam logic signed [ValW-1:0] RstBrakeThr     = -16'sd2048;
	localparam logic [LeverW-1:0]      RstLeverThr     = 11'd31;
	localparam logic [CurW-1:0]        RstMinBrakeCur  = 15'd0;
	localparam logic [CurW-1:0]        RstMaxBrakeCur  = 15'd12800;

	typedef struct packed {
		logic signed [ValW-1:0] roll_speed_threshold;
		logic signed [ValW-1:0] push_threshold;
		logic signed [ValW-1:0] decel_threshold;
		logic signed [ValW-1:0] brake_threshold;
		logic [LeverW-1:0]      lever_threshold;
		logic [CurW-1:0]        min_brake_current;
		logic [CurW-1:0]        max_brake_current;
	} cfg_t;

	typedef struct packed {
		logic signed [ValW-1:0] force_avg;
		logic signed [ValW-1:0] speed_avg;
		logic                   ctrl_alive;
		logic                   sensor_ready;
		logic                   sensor_fresh;
		logic [LeverW-1:0]      lever_pos;
		logic                   motor_brake_on;
		logic                   manual_block;
		logic signed [ValW-1:0] regulator_drive;
	} in_item_t;

	typedef struct packed {
		mode_t                  mode;
		cmd_t                   command;
		logic signed [ValW-1:0] amount;
		logic                   regulate_on;
		logic                   deadband_on;
	} out_item_t;

	// saturate a widened signed value to 16 bits
	function automatic logic signed [ValW-1:0] sat16(input logic signed [18:0] v);
		logic signed [ValW-1:0] r;
		if (v > 19'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[ValW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/amc_cfg_regs.sv =====
module amc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [amc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [amc_pkg::ValW-1:0]      cfg_data,
	output amc_pkg::cfg_t                 cfg
);

	amc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_speed_threshold <= amc_pkg::RstRollSpeedThr;
			cfg_q.push_threshold       <= amc_pkg::RstPushThr;
			cfg_q.decel_threshold      <= amc_pkg::RstDecelThr;
			cfg_q.brake_threshold      <= amc_pkg::RstBrakeThr;
			cfg_q.lever_threshold      <= amc_pkg::RstLeverThr;
			cfg_q.min_brake_current    <= amc_pkg::RstMinBrakeCur;
			cfg_q.max_brake_current    <= amc_pkg::RstMaxBrakeCur;
		end else if (cfg_valid) begin
			case (amc_pkg::cfg_reg_t'(cfg_index))
				amc_pkg::REG_ROLL_SPEED_THR: cfg_q.roll_speed_threshold <= cfg_data;
				amc_pkg::REG_PUSH_THR:       cfg_q.push_threshold       <= cfg_data;
				amc_pkg::REG_DECEL_THR:      cfg_q.decel_threshold      <= cfg_data;
				amc_pkg::REG_BRAKE_THR:      cfg_q.brake_threshold      <= cfg_data;
				amc_pkg::REG_LEVER_THR: begin
					cfg_q.lever_threshold <= cfg_data[amc_pkg::LeverW-1:0];
				end
				amc_pkg::REG_MIN_BRAKE_CUR: begin
					cfg_q.min_brake_current <= cfg_data[amc_pkg::CurW-1:0];
				end
				amc_pkg::REG_MAX_BRAKE_CUR: begin
					cfg_q.max_brake_current <= cfg_data[amc_pkg::CurW-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/amc_brake_calc.sv =====
module amc_brake_calc (
	input  amc_pkg::cfg_t                    cfg,
	input  logic [amc_pkg::LeverW-1:0]       lever_pos,
	output logic signed [amc_pkg::ValW-1:0]  brake_amt
);

	logic [amc_pkg::LeverW-1:0]     lev;
	logic signed [amc_pkg::ValW-1:0] span;
	logic signed [26:0]             prod;
	logic signed [17:0]             cur;
	logic signed [18:0]             neg;

	always_comb begin
		lev  = (lever_pos > amc_pkg::LeverFull) ? amc_pkg::LeverFull : lever_pos;
		span = $signed({1'b0, cfg.max_brake_current}) - $signed({1'b0, cfg.min_brake_current});
		prod = 27'(span) * 27'($signed({1'b0, lev}));
		// arithmetic shift gives floor division by full scale
		cur  = $signed({3'b000, cfg.min_brake_current}) + 18'($signed(prod[26:10]));
		neg  = -19'(amc_pkg::sat16(19'(cur)));
		brake_amt = amc_pkg::sat16(neg);
	end

endmodule

// ===== rtl/amc_mode_logic.sv =====
module amc_mode_logic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  amc_pkg::cfg_t                    cfg,
	input  amc_pkg::in_item_t                item,
	input  logic signed [amc_pkg::ValW-1:0]  brake_amt,
	output amc_pkg::out_item_t               result
);

	amc_pkg::mode_t mode_q, mode_d;
	// new drive value; its previous value never feeds a later tick
	logic signed [amc_pkg::ValW-1:0] drive_d;
	logic deadband_q, deadband_d;

	logic lever_on, lever_off, t_brake, t_init, stopped, low_force, push, alive;
	logic braking, regulating;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= amc_pkg::MODE_INIT;
			deadband_q <= 1'b1;
		end else if (advance) begin
			mode_q     <= mode_d;
			deadband_q <= deadband_d;
		end
	end

	always_comb begin
		alive     = item.ctrl_alive;
		lever_on  = item.lever_pos > cfg.lever_threshold;
		lever_off = item.lever_pos < cfg.lever_threshold;
		t_brake   = alive && (item.motor_brake_on || item.force_avg < cfg.brake_threshold
			|| lever_on);
		t_init    = !alive || !item.sensor_ready;
		stopped   = item.speed_avg < cfg.roll_speed_threshold;
		low_force = item.force_avg < cfg.push_threshold;
		push      = item.force_avg > cfg.push_threshold;

		mode_d     = mode_q;
		drive_d    = '0;
		deadband_d = deadband_q;

		case (mode_q)
			amc_pkg::MODE_WAIT: begin
				deadband_d = 1'b1;
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (t_init) mode_d = amc_pkg::MODE_INIT;
				else if (push && item.speed_avg > cfg.roll_speed_threshold && alive)
					mode_d = amc_pkg::MODE_ROLL;
				else if ((item.force_avg < cfg.brake_threshold || lever_on) && alive)
					mode_d = amc_pkg::MODE_BRAKE;
			end
			amc_pkg::MODE_ROLL: begin
				drive_d    = item.regulator_drive;
				deadband_d = 1'b0;
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (stopped && low_force && alive) mode_d = amc_pkg::MODE_WAIT;
				else if (t_init) mode_d = amc_pkg::MODE_INIT;
				else if (item.force_avg < amc_pkg::HalfQ88 && item.speed_avg > 16'sd0 && alive)
					mode_d = amc_pkg::MODE_HOLD;
			end
			amc_pkg::MODE_HOLD: begin
				drive_d = item.regulator_drive;
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (t_init) mode_d = amc_pkg::MODE_INIT;
				else if (stopped && low_force && alive) mode_d = amc_pkg::MODE_WAIT;
				else if (push && alive) mode_d = amc_pkg::MODE_ROLL;
				else if (item.force_avg < cfg.decel_threshold
					&& item.force_avg > cfg.brake_threshold && alive)
					mode_d = amc_pkg::MODE_DECEL;
			end
			amc_pkg::MODE_DECEL: begin
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (t_init) mode_d = amc_pkg::MODE_INIT;
				else if (push && alive) mode_d = amc_pkg::MODE_WAIT;
				else if (item.force_avg < cfg.brake_threshold && alive)
					mode_d = amc_pkg::MODE_BRAKE;
			end
			amc_pkg::MODE_BRAKE: begin
				deadband_d = 1'b1;
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (t_init) mode_d = amc_pkg::MODE_INIT;
				else if (lever_off && stopped && low_force && alive && !item.motor_brake_on)
					mode_d = amc_pkg::MODE_WAIT;
				else if (lever_off && alive && !item.motor_brake_on)
					mode_d = amc_pkg::MODE_ROLL;
			end
			default: begin
				deadband_d = 1'b1;
				mode_d     = amc_pkg::MODE_INIT;
				if (t_brake) mode_d = amc_pkg::MODE_BRAKE;
				else if (item.sensor_ready && stopped && alive) mode_d = amc_pkg::MODE_WAIT;
			end
		endcase

		braking    = (mode_d == amc_pkg::MODE_DECEL) || (mode_d == amc_pkg::MODE_BRAKE);
		regulating = (mode_d == amc_pkg::MODE_ROLL) || (mode_d == amc_pkg::MODE_HOLD);

		result.mode        = mode_d;
		result.regulate_on = regulating;
		result.deadband_on = deadband_d;
		result.command     = amc_pkg::CMD_SET_CURRENT;
		result.amount      = '0;
		if (item.manual_block) begin
			if (braking) begin
				result.command = amc_pkg::CMD_SET_BRAKE;
				result.amount  = brake_amt;
			end
		end else if (item.sensor_fresh && alive) begin
			if (regulating) begin
				result.command = (drive_d > 16'sd0) ? amc_pkg::CMD_SET_CURRENT
					: amc_pkg::CMD_SET_BRAKE;
				result.amount  = drive_d;
			end else if (braking) begin
				result.command = amc_pkg::CMD_SET_BRAKE;
				result.amount  = brake_amt;
			end else begin
				result.command = amc_pkg::CMD_NONE;
			end
		end
	end

endmodule

// ===== rtl/assist_mode_controller.sv =====
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    in_data   (amc_pkg::in_item_t, one tick of sensors)
// out       out  out_valid/out_ready  out_data  (amc_pkg::out_item_t, mode and command)
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// An input transaction is held in the input register; the mode/command logic
// then feeds its result into the output register.
// Throughput: one transaction per cycle unless out_ready stalls; the mode and deadband
// registers update in the same cycle the item moves into the output register.
// Reset: arst_n clears both pipeline valids, mode to init, deadband set,
// and the configuration registers to their defaults.
// Stalls: with out_ready low a full output register holds; the input register still
// takes one more transaction, then in_ready drops. cfg_ready is always high.
module assist_mode_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  amc_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output amc_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [amc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [amc_pkg::ValW-1:0]      cfg_data
);

	amc_pkg::cfg_t      cfg;
	amc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	amc_pkg::out_item_t result;
	amc_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic               out_free;
	logic               advance;
	logic signed [amc_pkg::ValW-1:0] brake_amt;

	// output slot is free when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	amc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	amc_brake_calc u_brake (
		.cfg       (cfg),
		.lever_pos (item_s1.lever_pos),
		.brake_amt (brake_amt)
	);

	amc_mode_logic u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cfg       (cfg),
		.item      (item_s1),
		.brake_amt (brake_amt),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/tb_assist_mode_controller.sv =====
module tb_assist_mode_controller;

	// ---------------------------------------------------------------------
	// Clock, reset and DUT ports
	// ---------------------------------------------------------------------
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	amc_pkg::in_item_t           in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	amc_pkg::out_item_t          out_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [amc_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [amc_pkg::ValW-1:0]    cfg_data  = '0;

	always #5 clk = ~clk;

	assist_mode_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------------
	// Mode machine predictor: its own copy of state and settings
	// ---------------------------------------------------------------------
	amc_pkg::mode_t                  mdl_mode;
	logic signed [amc_pkg::ValW-1:0] mdl_drive;
	logic                            mdl_deadband;
	amc_pkg::cfg_t                   mdl_cfg;

	amc_pkg::out_item_t pending_results[$];  // predicted results, oldest first
	int unsigned        fails = 0;
	bit                 calm  = 1'b0;        // set for the tail: no idling on either side

	function automatic logic signed [amc_pkg::ValW-1:0] clip16(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[amc_pkg::ValW-1:0];
	endfunction

	// negated lever interpolation between min and max brake current
	function automatic logic signed [amc_pkg::ValW-1:0] brake_current(
			logic [amc_pkg::LeverW-1:0] lever);
		int lev;
		int span;
		int cur;
		lev  = (lever > amc_pkg::LeverFull) ? 1024 : int'(lever);
		span = int'(mdl_cfg.max_brake_current) - int'(mdl_cfg.min_brake_current);
		// arithmetic shift floors negative products
		cur  = clip16(int'(mdl_cfg.min_brake_current) + ((span * lev) >>> 10));
		return clip16(-cur);
	endfunction

	function automatic void reset_model();
		mdl_mode     = amc_pkg::MODE_INIT;
		mdl_drive    = '0;
		mdl_deadband = 1'b1;
		mdl_cfg.roll_speed_threshold = amc_pkg::RstRollSpeedThr;
		mdl_cfg.push_threshold       = amc_pkg::RstPushThr;
		mdl_cfg.decel_threshold      = amc_pkg::RstDecelThr;
		mdl_cfg.brake_threshold      = amc_pkg::RstBrakeThr;
		mdl_cfg.lever_threshold      = amc_pkg::RstLeverThr;
		mdl_cfg.min_brake_current    = amc_pkg::RstMinBrakeCur;
		mdl_cfg.max_brake_current    = amc_pkg::RstMaxBrakeCur;
	endfunction

	// one control tick: mode work, transition, then command from the new mode
	function automatic amc_pkg::out_item_t step_mode_machine(amc_pkg::in_item_t t);
		int                 f;
		int                 s;
		int                 rol;
		int                 psh;
		int                 brk;
		logic               alive;
		logic               lev_on;
		logic               lev_off;
		logic               go_brake;
		logic               go_init;
		logic               is_stopped;
		logic               low_force;
		logic               high_force;
		logic               braking;
		logic               regulating;
		amc_pkg::mode_t     nm;
		amc_pkg::out_item_t r;

		f          = $signed(t.force_avg);
		s          = $signed(t.speed_avg);
		rol        = $signed(mdl_cfg.roll_speed_threshold);
		psh        = $signed(mdl_cfg.push_threshold);
		brk        = $signed(mdl_cfg.brake_threshold);
		alive      = t.ctrl_alive;
		lev_on     = t.lever_pos > mdl_cfg.lever_threshold;
		lev_off    = t.lever_pos < mdl_cfg.lever_threshold;
		go_brake   = alive && (t.motor_brake_on || f < brk || lev_on);
		go_init    = !alive || !t.sensor_ready;
		is_stopped = s < rol;
		low_force  = f < psh;
		high_force = f > psh;
		nm         = mdl_mode;

		case (mdl_mode)
			amc_pkg::MODE_WAIT: begin
				mdl_drive = '0;
				mdl_deadband = 1'b1;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (go_init)
					nm = amc_pkg::MODE_INIT;
				else if (high_force && s > rol && alive)
					nm = amc_pkg::MODE_ROLL;
				else if ((f < brk || lev_on) && alive)
					nm = amc_pkg::MODE_BRAKE;
			end
			amc_pkg::MODE_ROLL: begin
				mdl_drive = t.regulator_drive;
				mdl_deadband = 1'b0;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (is_stopped && low_force && alive)
					nm = amc_pkg::MODE_WAIT;
				else if (go_init)
					nm = amc_pkg::MODE_INIT;
				else if (f < int'(amc_pkg::HalfQ88) && s > 0 && alive)
					nm = amc_pkg::MODE_HOLD;
			end
			amc_pkg::MODE_HOLD: begin
				mdl_drive = t.regulator_drive;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (go_init)
					nm = amc_pkg::MODE_INIT;
				else if (is_stopped && low_force && alive)
					nm = amc_pkg::MODE_WAIT;
				else if (high_force && alive)
					nm = amc_pkg::MODE_ROLL;
				else if (f < $signed(mdl_cfg.decel_threshold) && f > brk && alive)
					nm = amc_pkg::MODE_DECEL;
			end
			amc_pkg::MODE_DECEL: begin
				mdl_drive = '0;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (go_init)
					nm = amc_pkg::MODE_INIT;
				else if (high_force && alive)
					nm = amc_pkg::MODE_WAIT;
				else if (f < brk && alive)
					nm = amc_pkg::MODE_BRAKE;
			end
			amc_pkg::MODE_BRAKE: begin
				mdl_drive = '0;
				mdl_deadband = 1'b1;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (go_init)
					nm = amc_pkg::MODE_INIT;
				else if (lev_off && is_stopped && low_force && alive && !t.motor_brake_on)
					nm = amc_pkg::MODE_WAIT;
				else if (lev_off && alive && !t.motor_brake_on)
					nm = amc_pkg::MODE_ROLL;
			end
			default: begin
				// init, and any unused code, behaves as init
				mdl_drive = '0;
				mdl_deadband = 1'b1;
				nm = amc_pkg::MODE_INIT;
				if (go_brake)
					nm = amc_pkg::MODE_BRAKE;
				else if (t.sensor_ready && is_stopped && alive)
					nm = amc_pkg::MODE_WAIT;
			end
		endcase
		mdl_mode = nm;

		braking    = (nm == amc_pkg::MODE_DECEL) || (nm == amc_pkg::MODE_BRAKE);
		regulating = (nm == amc_pkg::MODE_ROLL) || (nm == amc_pkg::MODE_HOLD);
		r.mode     = nm;
		r.command  = amc_pkg::CMD_NONE;
		r.amount   = '0;
		if (t.manual_block) begin
			if (braking) begin
				r.command = amc_pkg::CMD_SET_BRAKE;
				r.amount  = brake_current(t.lever_pos);
			end else begin
				r.command = amc_pkg::CMD_SET_CURRENT;
			end
		end else if (!t.sensor_fresh || !alive) begin
			r.command = amc_pkg::CMD_SET_CURRENT;
		end else if (regulating) begin
			// non-positive drive goes out as a brake command
			r.command = (mdl_drive > 0) ? amc_pkg::CMD_SET_CURRENT : amc_pkg::CMD_SET_BRAKE;
			r.amount  = mdl_drive;
		end else if (braking) begin
			r.command = amc_pkg::CMD_SET_BRAKE;
			r.amount  = brake_current(t.lever_pos);
		end
		r.regulate_on = regulating;
		r.deadband_on = mdl_deadband;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Result checker: every accepted result against the oldest prediction
	// ---------------------------------------------------------------------
	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		amc_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no prediction pending");
				fails++;
			end else begin
				want = pending_results.pop_front();
				check_field("mode", want.mode, out_data.mode);
				check_field("command", want.command, out_data.command);
				check_field("amount", want.amount, out_data.amount);
				check_field("regulate_on", want.regulate_on, out_data.regulate_on);
				check_field("deadband_on", want.deadband_on, out_data.deadband_on);
			end
		end
	end

	// Receiver: ready held high for stretches, dropped in random bursts while calm is clear
	initial begin
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	// one tick transaction; an optional idle burst first, predicted on acceptance
	task automatic send_tick(input amc_pkg::in_item_t t);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(step_mode_machine(t));
	endtask

	// stop sending and let every pending result drain, plus pipeline slack
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input amc_pkg::cfg_reg_t idx,
			input logic [amc_pkg::ValW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			amc_pkg::REG_ROLL_SPEED_THR: mdl_cfg.roll_speed_threshold = val;
			amc_pkg::REG_PUSH_THR:       mdl_cfg.push_threshold       = val;
			amc_pkg::REG_DECEL_THR:      mdl_cfg.decel_threshold      = val;
			amc_pkg::REG_BRAKE_THR:      mdl_cfg.brake_threshold      = val;
			amc_pkg::REG_LEVER_THR:
				mdl_cfg.lever_threshold = val[amc_pkg::LeverW-1:0];
			amc_pkg::REG_MIN_BRAKE_CUR:
				mdl_cfg.min_brake_current = val[amc_pkg::CurW-1:0];
			amc_pkg::REG_MAX_BRAKE_CUR:
				mdl_cfg.max_brake_current = val[amc_pkg::CurW-1:0];
			default: ;
		endcase
	endtask

	// full register set, written only with the pipeline empty
	task automatic apply_settings(input int roll, input int push, input int decel,
			input int brake, input int lever, input int minc, input int maxc);
		wait_idle();
		cfg_write(amc_pkg::REG_ROLL_SPEED_THR, roll[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_PUSH_THR, push[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_DECEL_THR, decel[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_BRAKE_THR, brake[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_LEVER_THR, lever[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_MIN_BRAKE_CUR, minc[amc_pkg::ValW-1:0]);
		cfg_write(amc_pkg::REG_MAX_BRAKE_CUR, maxc[amc_pkg::ValW-1:0]);
		cfg_valid <= 1'b0;
	endtask

	function automatic amc_pkg::in_item_t tick(int force_v, int speed_v, bit alive,
			bit ready, bit fresh, int lever, bit mb, bit block, int drive);
		amc_pkg::in_item_t t;
		t.force_avg       = force_v[amc_pkg::ValW-1:0];
		t.speed_avg       = speed_v[amc_pkg::ValW-1:0];
		t.ctrl_alive      = alive;
		t.sensor_ready    = ready;
		t.sensor_fresh    = fresh;
		t.lever_pos       = lever[amc_pkg::LeverW-1:0];
		t.motor_brake_on  = mb;
		t.manual_block    = block;
		t.regulator_drive = drive[amc_pkg::ValW-1:0];
		return t;
	endfunction

	// Mostly plausible ticks clustered around the live thresholds so the
	// machine walks through all modes; the rest is raw noise.
	function automatic amc_pkg::in_item_t random_tick();
		amc_pkg::in_item_t t;
		int                base;
		if ($urandom_range(0, 6) == 0) begin
			t = tick($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 2047), $urandom, $urandom, $urandom);
			return t;
		end
		case ($urandom_range(0, 5))
			0: base = $signed(mdl_cfg.push_threshold);
			1: base = $signed(mdl_cfg.decel_threshold);
			2: base = $signed(mdl_cfg.brake_threshold);
			3: base = int'(amc_pkg::HalfQ88);
			4: base = 0;
			default: base = $signed(16'($urandom));
		endcase
		t.force_avg = clip16(base + int'($urandom_range(0, 600)) - 300);
		if ($urandom_range(0, 3) == 0)
			t.speed_avg = $urandom;
		else
			t.speed_avg = clip16($signed(mdl_cfg.roll_speed_threshold) +
					int'($urandom_range(0, 600)) - 300);
		t.ctrl_alive     = $urandom_range(0, 24) != 0;
		t.sensor_ready   = $urandom_range(0, 24) != 0;
		t.sensor_fresh   = $urandom_range(0, 9) != 0;
		t.motor_brake_on = $urandom_range(0, 19) == 0;
		t.manual_block   = $urandom_range(0, 19) == 0;
		// lever usually released so braking can end
		if ($urandom_range(0, 4) == 0)
			t.lever_pos = $urandom_range(0, 1100);
		else if (mdl_cfg.lever_threshold == 0)
			t.lever_pos = '0;
		else
			t.lever_pos = $urandom_range(0, mdl_cfg.lever_threshold - 1);
		if ($urandom_range(0, 1) == 0)
			t.regulator_drive = clip16(int'($urandom_range(0, 400)) - 200);
		else
			t.regulator_drive = $urandom;
		return t;
	endfunction

	task automatic run_random(input int n);
		repeat (n) send_tick(random_tick());
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	// directed walk through every mode and command case at reset settings
	task automatic test_directed_walk();
		send_tick(tick(0, 0, 1, 0, 1, 0, 0, 0, 0));              // init held, sensor not ready, no command
		send_tick(tick(0, 0, 1, 1, 1, 0, 0, 0, 0));              // init -> wait
		send_tick(tick(512, 512, 1, 1, 1, 0, 0, 0, 300));        // wait -> roll, zero drive as brake
		send_tick(tick(512, 512, 1, 1, 1, 0, 0, 0, 32767));      // roll, max drive
		send_tick(tick(0, 512, 1, 1, 1, 0, 0, 0, -32768));       // roll -> hold, min drive
		send_tick(tick(-1500, 512, 1, 1, 1, 0, 0, 0, 100));      // hold -> decel
		send_tick(tick(512, 512, 1, 1, 1, 20, 0, 0, 0));         // decel -> wait
		send_tick(tick(0, 0, 1, 1, 1, 1024, 0, 0, 0));           // wait -> brake, full lever
		send_tick(tick(0, 0, 1, 1, 1, 2047, 0, 0, 0));           // lever above full scale
		send_tick(tick(0, 0, 1, 1, 1, 0, 0, 0, 0));              // brake -> wait
		send_tick(tick(0, 0, 1, 1, 1, 0, 1, 0, 0));              // motor brake switch
		send_tick(tick(512, 512, 1, 1, 1, 0, 0, 0, 50));         // brake -> roll
		send_tick(tick(-32768, 512, 1, 1, 1, 0, 0, 0, 0));       // force below brake level
		send_tick(tick(32767, 32767, 1, 1, 1, 31, 0, 0, 0));     // lever exactly at threshold
		send_tick(tick(32767, 32767, 0, 1, 1, 0, 0, 0, 0));      // controller dead -> init
		send_tick(tick(0, 0, 1, 1, 0, 0, 0, 0, 0));              // stale sensor
		send_tick(tick(0, 0, 1, 1, 1, 0, 0, 1, 0));              // manual block, not braking
		send_tick(tick(0, 0, 1, 1, 1, 512, 0, 1, 0));            // manual block while braking
		send_tick(tick(0, -32768, 1, 1, 1, 0, 0, 0, 0));         // brake -> wait, min speed
		send_tick(tick(512, 512, 1, 1, 1, 0, 0, 0, -1));         // wait -> roll
		send_tick(tick(0, 0, 1, 0, 1, 0, 0, 0, 0));              // roll -> wait (stopped first)
		send_tick(tick(0, 0, 1, 0, 1, 0, 0, 0, 0));              // wait -> init, not ready
	endtask

	task automatic test_random_reset_settings();
		run_random(220);
	endtask

	// register writes: both extremes, negative span, plausible and random sets
	task automatic test_register_settings();
		apply_settings(-32768, -32768, -32768, -32768, 0, 0, 0);
		run_random(55);
		apply_settings(32767, 32767, 32767, 32767, 1024, 32767, 32767);
		run_random(55);
		apply_settings(256, 256, -1024, -2048, 1024, 32767, 0);
		run_random(55);
		apply_settings($urandom_range(0, 1024), $urandom_range(0, 1024),
				-int'($urandom_range(256, 2048)), -int'($urandom_range(2048, 6000)),
				$urandom_range(1, 200), $urandom_range(0, 5000),
				$urandom_range(5000, 32767));
		run_random(55);
		apply_settings($signed(16'($urandom)), $signed(16'($urandom)),
				$signed(16'($urandom)), $signed(16'($urandom)),
				$urandom_range(0, 1024), $urandom_range(0, 32767),
				$urandom_range(0, 32767));
		run_random(55);
	endtask

	// back-to-back traffic at reset values with no idling
	task automatic test_calm_tail();
		apply_settings(amc_pkg::RstRollSpeedThr, amc_pkg::RstPushThr,
				amc_pkg::RstDecelThr, amc_pkg::RstBrakeThr, amc_pkg::RstLeverThr,
				amc_pkg::RstMinBrakeCur, amc_pkg::RstMaxBrakeCur);
		calm = 1'b1;
		run_random(110);
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_walk();
		test_random_reset_settings();
		test_register_settings();
		test_calm_tail();

		wait_idle();
		repeat (8) @(posedge clk);
		if (fails == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
